>>> design/raycast_wall_column_shader_defines.svh
// assertion macros shared by the checker
`ifndef RAYCAST_WALL_COLUMN_SHADER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_SHADER_DEFINES_SVH

// same-cycle implication
`define RCS_ASSERT_NOW(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("rcs check failed");

// next-cycle implication
`define RCS_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("rcs check failed");

`endif

>>> design/rcs_pkg.sv
package rcs_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int TILE_EDGE     = 64;
  localparam int TEX_WIDTH     = 64;
  localparam int TEX_HEIGHT    = 64;
  localparam int TEXTURE_COUNT = 8;

  localparam int TEX_SIZE    = TEX_WIDTH * TEX_HEIGHT;
  localparam int STORE_DEPTH = 32768;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int TX_W        = $clog2(TEX_WIDTH);
  localparam int TY_W        = $clog2(TEX_HEIGHT);
  localparam int TEX_W       = 4;

  localparam int APB_AW = 4;

  localparam logic [23:0] PROJ_RST  = 24'd227017;
  localparam logic [31:0] CEIL_RST  = 32'hFF990000;
  localparam logic [31:0] FLOOR_RST = 32'hFF003355;

  localparam int PI_Q12 = 12868;
  localparam logic [30:0] PI_SQ = 31'(PI_Q12 * PI_Q12);
  localparam logic [23:0] HEIGHT_CAP = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_PROJ  = 2'd0,
    REG_CEIL  = 2'd1,
    REG_FLOOR = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    REGION_CEILING = 2'd0,
    REGION_WALL    = 2'd1,
    REGION_FLOOR   = 2'd2
  } region_e;

endpackage

>>> design/rcs_if.sv
interface rcs_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [8:0]  row;
  logic [9:0]  column;
  logic [23:0] ray_distance;
  logic signed [14:0] angle_offset;
  logic [15:0] hit_x;
  logic [15:0] hit_y;
  logic        hit_vertical;
  logic [3:0]  wall_type;
  logic [14:0] load_address;
  logic [31:0] load_color;

  modport source (output valid, cmd, row, column, ray_distance, angle_offset, hit_x, hit_y,
                  hit_vertical, wall_type, load_address, load_color, input ready);
  modport sink (input valid, cmd, row, column, ray_distance, angle_offset, hit_x, hit_y,
                hit_vertical, wall_type, load_address, load_color, output ready);
endinterface

interface rcs_pixel_if;
  logic        valid;
  logic        ready;
  logic [18:0] pixel_address;
  logic [31:0] pixel_color;
  logic [1:0]  region;

  modport source (output valid, pixel_address, pixel_color, region, input ready);
  modport sink (input valid, pixel_address, pixel_color, region, output ready);
endinterface

>>> design/rcs_ram.sv
module rcs_ram #(
  parameter int Width = 32,
  parameter int Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/raycast_wall_column_shader.sv
// channel   | dir | handshake     | payload
// item_i    | in  | valid / ready | cmd, row, column, ray data, hit, wall_type, load fields
// pixel_o   | out | valid / ready | pixel_address, pixel_color, region
// apb       | in  | psel/penable  | projection_distance, ceiling_color, floor_color
//
// one transaction per cycle while no result waits on pixel_o
// the dividers resolve one bit per stage (cosine 13, height 24, texel row 6 stages)
// the texture memory is read or written in one stage, in transaction order
// the whole pipeline holds while a result waits on pixel_o
// reset clears valid bits and the config registers, texture memory is not cleared
module raycast_wall_column_shader (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  rcs_item_if.sink                   item_i,
  rcs_pixel_if.source                pixel_o
);
  import rcs_pkg::*;

  localparam int X_W    = 15;
  localparam int X2_W   = 29;
  localparam int CREM_W = 41;
  localparam int CDEN_W = 29;
  localparam int COS_N  = 13;
  localparam int HR_W   = 48;
  localparam int H_N    = 24;
  localparam int T_W    = 26 + TY_W;

  localparam int ST_COS0  = 3;
  localparam int ST_PERP  = ST_COS0 + COS_N;
  localparam int ST_HSAT  = ST_PERP + 1;
  localparam int ST_H0    = ST_HSAT + 1;
  localparam int ST_SHADE = ST_H0 + H_N;
  localparam int ST_TY0   = ST_SHADE + 1;
  localparam int ST_ADDR  = ST_TY0 + TY_W;
  localparam int N_ST     = ST_ADDR + 1;

  localparam logic [24:0] MID = 25'(SCREEN_HEIGHT / 2);
  localparam logic [24:0] SH  = 25'(SCREEN_HEIGHT);

  typedef struct packed {
    logic                load;
    logic [8:0]          row;
    logic [9:0]          column;
    logic [23:0]         ray_dist;
    logic [TX_W-1:0]     tx;
    logic [TEX_W-1:0]    tex;
    logic [14:0]         laddr;
    logic [31:0]         lcolor;
    logic [X_W-1:0]      x;
    logic [X2_W-1:0]     x2;
    logic [CREM_W-1:0]   crem;
    logic [CDEN_W-1:0]   cden;
    logic [COS_N-1:0]    cq;
    logic [23:0]         perp;
    logic                hsat;
    logic [HR_W-1:0]     hrem;
    logic [H_N-1:0]      hq;
    logic [23:0]         height;
    region_e             region;
    logic [T_W-1:0]      trem;
    logic                tsat;
    logic [TY_W-1:0]     tq;
  } item_t;

  logic [23:0] proj_q;
  logic [31:0] ceil_q, floor_q;

  item_t st_q [N_ST];
  item_t st_d [N_ST];
  logic [N_ST-1:0] vld_q;

  logic        out_vld_q;
  logic [18:0] out_addr_q;
  logic [31:0] out_color_q;
  region_e     out_region_q;

  logic advance;
  logic onscreen;

  logic                ram_en;
  logic [STORE_AW-1:0] ram_addr;
  logic [31:0]         ram_rdata;
  logic [TY_W-1:0]     ty_fin;

  // config port
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_e'(paddr[APB_AW-1:2]))
      REG_PROJ:  prdata = {8'b0, proj_q};
      REG_CEIL:  prdata = ceil_q;
      REG_FLOOR: prdata = floor_q;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q  <= PROJ_RST;
      ceil_q  <= CEIL_RST;
      floor_q <= FLOOR_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[APB_AW-1:2]))
        REG_PROJ:  proj_q  <= pwdata[23:0];
        REG_CEIL:  ceil_q  <= pwdata;
        REG_FLOOR: floor_q <= pwdata;
        default:   ;
      endcase
    end
  end

  // pipeline control
  assign advance      = !out_vld_q || pixel_o.ready;
  assign item_i.ready = advance;
  assign onscreen     = (32'(item_i.row) < SCREEN_HEIGHT) && (32'(item_i.column) < SCREEN_WIDTH);

  always_comb begin
    logic [15:0]       a16;
    logic [15:0]       sel;
    logic [TEX_W-1:0]  tex;
    logic [30:0]       four_x2;
    logic [CREM_W-1:0] cdsh;
    logic [HR_W-1:0]   hnum;
    logic [HR_W-1:0]   hdsh;
    logic [23:0]       h;
    logic [23:0]       half;
    logic [24:0]       top;
    logic [24:0]       bsum;
    logic [24:0]       bottom;
    logic [T_W-1:0]    tdsh;
    logic [36:0]       prod;
    int                i;

    a16  = {1'b0, item_i.angle_offset};
    sel  = item_i.hit_vertical ? item_i.hit_y : item_i.hit_x;
    tex  = (item_i.wall_type == '0) ? '0 : item_i.wall_type - 1'b1;
    if (32'(tex) > TEXTURE_COUNT - 1) begin
      tex = TEX_W'(TEXTURE_COUNT - 1);
    end

    st_d[0]          = st_q[0];
    st_d[0].load     = item_i.cmd;
    st_d[0].row      = item_i.row;
    st_d[0].column   = item_i.column;
    st_d[0].ray_dist = item_i.ray_distance;
    st_d[0].tx       = TX_W'((32'(sel) % TILE_EDGE) % TEX_WIDTH);
    st_d[0].tex      = tex;
    st_d[0].laddr    = item_i.load_address;
    st_d[0].lcolor   = item_i.load_color;
    st_d[0].x        = X_W'(a16[14] ? (16'h8000 - a16) : a16);

    four_x2 = '0;
    cdsh    = '0;
    hnum    = '0;
    hdsh    = '0;
    h       = '0;
    half    = '0;
    top     = '0;
    bsum    = '0;
    bottom  = '0;
    tdsh    = '0;
    prod    = '0;
    i       = 0;

    for (int k = 1; k < N_ST; k++) begin
      st_d[k] = st_q[k-1];
      if (k == 1) begin
        st_d[k].x2 = X2_W'(X2_W'(st_q[k-1].x) * X2_W'(st_q[k-1].x));
      end else if (k == 2) begin
        four_x2 = {st_q[k-1].x2, 2'b00};
        if (four_x2 >= PI_SQ) begin
          st_d[k].crem = '0;
        end else begin
          st_d[k].crem = CREM_W'(PI_SQ - four_x2) << 12;
        end
        st_d[k].cden = CDEN_W'(PI_SQ) + st_q[k-1].x2;
        st_d[k].cq   = '0;
      end else if (k >= ST_COS0 && k < ST_PERP) begin
        i    = COS_N - 1 - (k - ST_COS0);
        cdsh = CREM_W'(st_q[k-1].cden) << i;
        if (st_q[k-1].crem >= cdsh) begin
          st_d[k].crem  = st_q[k-1].crem - cdsh;
          st_d[k].cq[i] = 1'b1;
        end
      end else if (k == ST_PERP) begin
        prod         = 37'(st_q[k-1].ray_dist) * 37'(st_q[k-1].cq);
        st_d[k].perp = prod[35:12];
      end else if (k == ST_HSAT) begin
        hnum         = HR_W'(TILE_EDGE) * HR_W'(proj_q);
        st_d[k].hsat = (st_q[k-1].perp == '0) || (hnum >= (HR_W'(st_q[k-1].perp) << H_N));
        st_d[k].hrem = hnum;
        st_d[k].hq   = '0;
      end else if (k >= ST_H0 && k < ST_SHADE) begin
        i    = H_N - 1 - (k - ST_H0);
        hdsh = HR_W'(st_q[k-1].perp) << i;
        if (st_q[k-1].hrem >= hdsh) begin
          st_d[k].hrem  = st_q[k-1].hrem - hdsh;
          st_d[k].hq[i] = 1'b1;
        end
      end else if (k == ST_SHADE) begin
        h      = st_q[k-1].hsat ? HEIGHT_CAP : st_q[k-1].hq;
        half   = h >> 1;
        top    = ({1'b0, half} >= MID) ? '0 : MID - {1'b0, half};
        bsum   = MID + {1'b0, half};
        bottom = (bsum > SH) ? SH : bsum;
        st_d[k].height = h;
        if (25'(st_q[k-1].row) < top) begin
          st_d[k].region = REGION_CEILING;
        end else if (25'(st_q[k-1].row) < bottom && h != '0) begin
          st_d[k].region = REGION_WALL;
        end else begin
          st_d[k].region = REGION_FLOOR;
        end
        st_d[k].trem = T_W'((T_W'(st_q[k-1].row) + T_W'(half) - T_W'(MID)) * T_W'(TEX_HEIGHT));
        st_d[k].tsat = st_d[k].trem >= T_W'(T_W'(h) * T_W'(TEX_HEIGHT));
        st_d[k].tq   = '0;
      end else if (k >= ST_TY0 && k < ST_ADDR) begin
        i    = TY_W - 1 - (k - ST_TY0);
        tdsh = T_W'(st_q[k-1].height) << i;
        if (st_q[k-1].trem >= tdsh) begin
          st_d[k].trem  = st_q[k-1].trem - tdsh;
          st_d[k].tq[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[N_ST-2:0], item_i.valid && (item_i.cmd || onscreen)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < N_ST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // texture memory, at most one access per transaction (loads and wall pixels) in pipeline order
  assign ty_fin = st_q[ST_ADDR-1].tsat ? TY_W'(TEX_HEIGHT - 1) : st_q[ST_ADDR-1].tq;
  assign ram_en = advance && vld_q[ST_ADDR-1] &&
                  (st_q[ST_ADDR-1].load || st_q[ST_ADDR-1].region == REGION_WALL);
  assign ram_addr = st_q[ST_ADDR-1].load ? STORE_AW'(st_q[ST_ADDR-1].laddr) :
                    STORE_AW'(32'(st_q[ST_ADDR-1].tex) * TEX_SIZE +
                              32'(ty_fin) * TEX_WIDTH + 32'(st_q[ST_ADDR-1].tx));

  rcs_ram #(
    .Width (32),
    .Depth (STORE_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (st_q[ST_ADDR-1].load),
    .addr_i  (ram_addr),
    .wdata_i (st_q[ST_ADDR-1].lcolor),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= vld_q[ST_ADDR] && !st_q[ST_ADDR].load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_addr_q   <= 19'(32'(st_q[ST_ADDR].row) * SCREEN_WIDTH + 32'(st_q[ST_ADDR].column));
      out_region_q <= st_q[ST_ADDR].region;
      case (st_q[ST_ADDR].region)
        REGION_CEILING: out_color_q <= ceil_q;
        REGION_WALL:    out_color_q <= ram_rdata;
        default:        out_color_q <= floor_q;
      endcase
    end
  end

  assign pixel_o.valid         = out_vld_q;
  assign pixel_o.pixel_address = out_addr_q;
  assign pixel_o.pixel_color   = out_color_q;
  assign pixel_o.region        = out_region_q;

endmodule

>>> design/rcs_checker.sv
`include "raycast_wall_column_shader_defines.svh"

module rcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [18:0] out_address,
  input logic [31:0] out_color,
  input logic [1:0]  out_region
);

  `RCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `RCS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, $stable(out_address) && $stable(out_color) && $stable(out_region))
  `RCS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready, out_valid && !out_ready)

endmodule

bind raycast_wall_column_shader rcs_checker u_rcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (item_i.ready),
  .out_valid   (pixel_o.valid),
  .out_ready   (pixel_o.ready),
  .out_address (pixel_o.pixel_address),
  .out_color   (pixel_o.pixel_color),
  .out_region  (pixel_o.region)
);
